>>> rtl/core/ilc_pkg.sv
// Shared types and constants for the interval locator with edge distances.
package ilc_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int IdxW       = 10;
  localparam int PosW       = 32;

  typedef enum logic [0:0] {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StReadLast,
    StCheck,
    StSearch,
    StOut
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] boundary_index;
    logic [PosW-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] segment_index;
    logic [PosW-1:0] start_offset;
    logic [PosW-1:0] end_offset;
    logic            miss;
  } out_item_t;

endpackage

>>> rtl/core/ilc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/interval_locator_edge_distance.sv
// Top level of the interval locator: boundary table, search sequencer, result register.
//
// Usage:
//   Items enter on item_i, taken at a rising edge with start high and busy low.
//   A load item (op = load) writes position into table slot boundary_index in the
//   accept cycle and gives no result; busy stays low, so loads go at one per cycle while no query is in flight.
//   A query item (with a nonzero segment count) raises busy and runs a binary search over
//   the boundary table, one dependent table read per cycle from the single read port of the RAM.
//   The result appears on result_o for exactly one cycle with strobe_o high;
//   the receiver cannot hold it off, and busy is already low in that cycle.
//   A query reads the first and then the last boundary, checks for a miss, then
//   runs ceil(log2(segments)) halving steps, one per cycle, and last forms the
//   offsets. A miss found by the check is reported without any halving step;
//   with zero segments, the miss is shown in the cycle after accept.
//   The segment count register is written on the cfg channel (valid/ready);
//   ready is high whenever no query is in flight.
//   Reset clears the sequencer and sets the segment count to 1; the table
//   itself is not cleared and must be loaded before it is queried.
module interval_locator_edge_distance
  import ilc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  in_item_t        item_i,
  output logic            strobe_o,
  output out_item_t       result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_data_i
);

  // Control state
  state_e          state_q, state_d;
  logic            strobe_q, strobe_d;
  logic [IdxW-1:0] cfg_q, cfg_d;

  // Working payload of the query in flight
  logic [PosW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] n_q, n_d;
  logic [IdxW-1:0] lo_q, lo_d;
  logic [IdxW-1:0] hi_q, hi_d;
  logic [IdxW-1:0] mid_q, mid_d;
  logic [PosW-1:0] b_lo_q, b_lo_d;
  logic [PosW-1:0] b_hi_q, b_hi_d;
  logic            miss_lo_q, miss_lo_d;
  out_item_t       res_q, res_d;

  // Table RAM
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [PosW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [PosW-1:0]  ram_rdata;

  ilc_ram #(
    .Width(PosW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic            accept;
  logic [IdxW-1:0] seg_used;
  logic            slot_ok;
  logic            le;
  logic [IdxW-1:0] lo_nx, hi_nx;
  logic [IdxW:0]   sum_nx;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = !busy;
  assign strobe_o    = strobe_q;
  assign result_o    = res_q;

  // Limit the segment count to what the table can hold.
  assign seg_used = (32'(cfg_q) > 32'(TableDepth - 1)) ? IdxW'(TableDepth - 1) : cfg_q;
  assign slot_ok  = (32'(item_i.boundary_index) < 32'(TableDepth));

  // One halving step: boundary at mid against the position.
  assign le     = (ram_rdata <= pos_q);
  assign lo_nx  = le ? mid_q : lo_q;
  assign hi_nx  = le ? hi_q : mid_q;
  assign sum_nx = {1'b0, lo_nx} + {1'b0, hi_nx};

  // Loads write in the accept cycle; queries never read in the same cycle.
  assign ram_we    = accept && (item_i.op == OpLoad) && slot_ok;
  assign ram_waddr = AddrW'(item_i.boundary_index);
  assign ram_wdata = item_i.position;

  always_comb begin
    state_d   = state_q;
    strobe_d  = 1'b0;
    cfg_d     = cfg_q;
    pos_d     = pos_q;
    n_d       = n_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    b_lo_d    = b_lo_q;
    b_hi_d    = b_hi_q;
    miss_lo_d = miss_lo_q;
    res_d     = res_q;
    ram_raddr = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    unique case (state_q)
      StIdle: begin
        // Read the first boundary right away so it is back next cycle.
        ram_raddr = '0;
        if (accept && item_i.op == OpQuery) begin
          pos_d = item_i.position;
          n_d   = seg_used;
          if (seg_used == '0) begin
            // No segments: every query misses.
            res_d    = '{segment_index: '0, start_offset: '0, end_offset: '0, miss: 1'b1};
            strobe_d = 1'b1;
          end else begin
            state_d = StReadLast;
          end
        end
      end
      StReadLast: begin
        // First boundary is back; fetch the last one.
        b_lo_d    = ram_rdata;
        miss_lo_d = (pos_q < ram_rdata);
        ram_raddr = AddrW'(n_q);
        state_d   = StCheck;
      end
      StCheck: begin
        b_hi_d = ram_rdata;
        lo_d   = '0;
        hi_d   = n_q;
        mid_d  = n_q >> 1;
        ram_raddr = AddrW'(n_q >> 1);
        if (miss_lo_q || pos_q >= ram_rdata) begin
          res_d    = '{segment_index: '0, start_offset: '0, end_offset: '0, miss: 1'b1};
          strobe_d = 1'b1;
          state_d  = StIdle;
        end else if (n_q > IdxW'(1)) begin
          state_d = StSearch;
        end else begin
          state_d = StOut;
        end
      end
      StSearch: begin
        // Narrow the interval and issue the next probe in the same cycle.
        lo_d   = lo_nx;
        hi_d   = hi_nx;
        b_lo_d = le ? ram_rdata : b_lo_q;
        b_hi_d = le ? b_hi_q : ram_rdata;
        mid_d  = sum_nx[IdxW:1];
        ram_raddr = AddrW'(sum_nx[IdxW:1]);
        if ((hi_nx - lo_nx) > IdxW'(1)) begin
          state_d = StSearch;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        res_d.segment_index = lo_q;
        res_d.start_offset  = pos_q - b_lo_q;
        res_d.end_offset    = b_hi_q - pos_q;
        res_d.miss          = 1'b0;
        strobe_d            = 1'b1;
        state_d             = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
      cfg_q    <= IdxW'(1);
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      cfg_q    <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    n_q       <= n_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    b_lo_q    <= b_lo_d;
    b_hi_q    <= b_hi_d;
    miss_lo_q <= miss_lo_d;
    res_q     <= res_d;
  end

  // A load never produces a result and never holds the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OpLoad) |=> (!busy && !strobe_o))
    else $error("load item produced a result or raised busy");

  // Every result leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while a query is still in flight");

  // A miss carries zero index and offsets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.miss) |->
      (result_o.segment_index == '0 && result_o.start_offset == '0 &&
       result_o.end_offset == '0))
    else $error("miss result with nonzero fields");

  // During the search the probe lies strictly inside the interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (lo_q < mid_q && mid_q < hi_q))
    else $error("search probe outside the open interval");

  // The output step is always followed by a hit result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> (strobe_o && !result_o.miss))
    else $error("hit result not delivered after the final step");

endmodule
